/* sv/arq_pkg.sv */
// Package for the ARQ send window tracker: constants, codes, shared types.
// No dependencies.
`default_nettype none
package arq_pkg;
    localparam int WINDOW_SLOTS = 32;
    localparam int SLOT_W = $clog2(WINDOW_SLOTS);
    localparam int CNT_W = $clog2(WINDOW_SLOTS + 1);

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [2:0] KIND_SENT    = 3'd0;
    localparam logic [2:0] KIND_REFUSED = 3'd1;
    localparam logic [2:0] KIND_RETX    = 3'd2;
    localparam logic [2:0] KIND_CLOSED  = 3'd3;
    localparam logic [2:0] KIND_DONE    = 3'd4;

    localparam logic [15:0] RTT_LIMIT = 16'd10000;
    localparam logic [11:0] RTO_MIN = 12'd100;
    localparam logic [11:0] RTO_MAX = 12'd2000;
    localparam logic [7:0] DUP_FAST = 8'd3;

    localparam logic [0:0] REG_DEFAULT_RTO = 1'd0;
    localparam logic [0:0] REG_MAX_RETRIES = 1'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] ack_seq;
        logic [31:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  slot;
        logic [15:0] seq;
        logic [5:0]  cleared;
        logic [5:0]  in_flight;
        logic [15:0] rto_ms;
        logic        last;
    } res_t;
endpackage
`default_nettype wire

/* sv/arq_req_fifo.sv */
// Short request queue between the input side and the window engine.
// Depends on arq_pkg.
`default_nettype none
module arq_req_fifo (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              in_valid,
    output logic             in_ready,
    input  arq_pkg::req_t    in_req,
    output logic             out_valid,
    input  wire              out_ready,
    output arq_pkg::req_t    out_req
);
    import arq_pkg::*;
    req_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= in_req;
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_nopush_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !push) else $error("push into full queue");
    a_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
endmodule
`default_nettype wire

/* sv/arq_engine.sv */
// Window engine: executes send requests directly and ack and tick requests slot by slot.
// Depends on arq_pkg.
`default_nettype none
module arq_engine (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              req_valid,
    output logic             req_ready,
    input  arq_pkg::req_t    req,
    output logic             res_valid,
    input  wire              res_ready,
    output arq_pkg::res_t    res,
    input  wire  [15:0]      default_rto,
    input  wire  [7:0]       max_retries
);
    import arq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ACK_SCAN, S_RTT1, S_RTT2, S_RTT3, S_CLEAR, S_TICK_RD, S_TICK,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [WINDOW_SLOTS-1:0] valid_reg;
    logic [15:0] seq_mem [WINDOW_SLOTS];
    logic [31:0] time_mem [WINDOW_SLOTS];
    logic [7:0]  retry_mem [WINDOW_SLOTS];
    logic [15:0] next_tx_reg, last_acked_reg;
    logic [7:0]  dup_reg;
    logic        fast_done_reg, rtt_valid_reg;
    logic [13:0] srtt_reg, var_reg;
    logic [11:0] rto_reg;
    logic [CNT_W-1:0] count_reg;
    req_t        cur_reg;
    logic [CNT_W-1:0] k_reg;
    logic [CNT_W-1:0] cleared_reg;
    logic        found_reg, newer_reg;
    logic [15:0] cand_reg;
    logic [31:0] oldest_reg;
    logic [31:0] sample_reg;
    logic [13:0] srtt_new_reg;
    logic [15:0] rs_seq_reg;
    logic [31:0] rs_time_reg;
    logic [7:0]  rs_retry_reg;
    logic        rs_valid_reg;
    res_t        res_reg;
    logic        res_valid_reg;

    logic [SLOT_W-1:0] k_idx;
    logic [SLOT_W-1:0] tx_idx;
    logic [15:0] rto_now;
    logic [15:0] d_ack, d_last, d_cand, d_tx;
    logic [31:0] elapsed;
    logic [8:0]  retry_inc;
    logic [16:0] srtt_sum;
    logic [15:0] diff_abs;
    logic [16:0] var_sum;
    logic [17:0] rto_sum;
    logic        out_free;

    assign k_idx   = k_reg[SLOT_W-1:0];
    assign tx_idx  = next_tx_reg[SLOT_W-1:0];
    assign rto_now = (rto_reg != 12'd0) ? {4'd0, rto_reg} : default_rto;
    assign d_ack   = seq_mem[k_idx] - cur_reg.ack_seq;
    assign d_last  = seq_mem[k_idx] - last_acked_reg;
    assign d_cand  = seq_mem[k_idx] - cand_reg;
    assign d_tx    = next_tx_reg - rs_seq_reg;
    assign elapsed = cur_reg.now_ms - rs_time_reg;
    assign retry_inc = {1'b0, rs_retry_reg} + 9'd1;
    assign srtt_sum = {3'd0, srtt_reg} * 17'd7 + {1'b0, sample_reg[15:0]};
    assign diff_abs = ({2'd0, srtt_new_reg} > sample_reg[15:0]) ?
        {2'd0, srtt_new_reg} - sample_reg[15:0] : sample_reg[15:0] - {2'd0, srtt_new_reg};
    assign var_sum = {3'd0, var_reg} * 17'd3 + {1'b0, diff_abs};
    assign rto_sum = {4'd0, srtt_reg} + {2'd0, var_reg, 2'b00};
    assign out_free = !res_valid_reg || res_ready;

    assign req_ready = (state_reg == S_IDLE) && out_free;
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    // Positive distance test for the tick scan (1..WINDOW_SLOTS).
    logic d_in, d_stale;
    always_comb begin
        d_in = !d_tx[15] && d_tx != 16'd0 && d_tx <= 16'(WINDOW_SLOTS);
        d_stale = d_tx[15] ? ((16'd0 - d_tx) > 16'(WINDOW_SLOTS))
                           : (d_tx > 16'(WINDOW_SLOTS));
    end

    always_ff @(posedge aclk) begin
        if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
        unique case (state_reg)
        S_IDLE: begin
            if (req_valid && out_free) begin
                cur_reg <= req;
                k_reg <= '0;
                cleared_reg <= '0;
                found_reg <= 1'b0;
                unique case (req.command)
                CMD_SEND: begin
                    res_valid_reg <= 1'b1;
                    res_reg.slot <= 5'(tx_idx);
                    res_reg.seq <= next_tx_reg;
                    res_reg.cleared <= 6'd0;
                    res_reg.rto_ms <= rto_now;
                    res_reg.last <= 1'b1;
                    if (count_reg >= CNT_W'(WINDOW_SLOTS) || valid_reg[tx_idx]) begin
                        res_reg.kind <= KIND_REFUSED;
                        res_reg.in_flight <= 6'(count_reg);
                    end else begin
                        res_reg.kind <= KIND_SENT;
                        res_reg.in_flight <= 6'(count_reg + 1'b1);
                        valid_reg[tx_idx] <= 1'b1;
                        seq_mem[tx_idx] <= next_tx_reg;
                        time_mem[tx_idx] <= req.now_ms;
                        retry_mem[tx_idx] <= 8'd0;
                        count_reg <= count_reg + 1'b1;
                        next_tx_reg <= next_tx_reg + 16'd1;
                    end
                end
                CMD_ACK: begin
                    newer_reg <= 1'b0;
                    if (req.ack_seq == last_acked_reg) begin
                        state_reg <= S_CLEAR;
                        if (dup_reg != 8'hFF) dup_reg <= dup_reg + 8'd1;
                        if (dup_reg + 8'd1 >= DUP_FAST && dup_reg != 8'hFF || dup_reg == 8'hFF)
                        begin
                            if (!fast_done_reg && valid_reg[req.ack_seq[SLOT_W-1:0]]
                                && seq_mem[req.ack_seq[SLOT_W-1:0]] == req.ack_seq) begin
                                time_mem[req.ack_seq[SLOT_W-1:0]] <= req.now_ms;
                                fast_done_reg <= 1'b1;
                                res_valid_reg <= 1'b1;
                                res_reg.kind <= KIND_RETX;
                                res_reg.slot <= 5'(req.ack_seq[SLOT_W-1:0]);
                                res_reg.seq <= req.ack_seq;
                                res_reg.cleared <= 6'd0;
                                res_reg.in_flight <= 6'(count_reg);
                                res_reg.rto_ms <= rto_now;
                                res_reg.last <= 1'b0;
                            end
                        end
                    end else if (!(req.ack_seq - last_acked_reg >= 16'h8000)) begin
                        newer_reg <= 1'b1;
                        state_reg <= S_ACK_SCAN;
                    end else begin
                        state_reg <= S_CLEAR;
                    end
                end
                CMD_TICK: state_reg <= S_TICK_RD;
                default: begin
                    res_valid_reg <= 1'b1;
                    res_reg <= '{kind: KIND_DONE, slot: 5'd0, seq: 16'd0, cleared: 6'd0,
                                 in_flight: 6'(count_reg), rto_ms: rto_now, last: 1'b1};
                end
                endcase
            end
        end
        S_ACK_SCAN: begin
            // Find the oldest packet covered by this ack.
            if (valid_reg[k_idx] && d_ack[15] && !d_last[15]) begin
                if (!found_reg || d_cand[15]) begin
                    found_reg <= 1'b1;
                    cand_reg <= seq_mem[k_idx];
                    oldest_reg <= time_mem[k_idx];
                end
            end
            if (k_reg == CNT_W'(WINDOW_SLOTS - 1)) begin
                k_reg <= '0;
                state_reg <= S_RTT1;
            end else k_reg <= k_reg + 1'b1;
        end
        S_RTT1: begin
            sample_reg <= cur_reg.now_ms - oldest_reg;
            state_reg <= S_RTT2;
            last_acked_reg <= cur_reg.ack_seq;
            dup_reg <= 8'd0;
            fast_done_reg <= 1'b0;
        end
        S_RTT2: begin
            if (found_reg && sample_reg != 32'd0 && sample_reg < {16'd0, RTT_LIMIT}) begin
                if (!rtt_valid_reg) begin
                    srtt_new_reg <= sample_reg[13:0];
                    srtt_reg <= sample_reg[13:0];
                    var_reg <= sample_reg[14:1];
                    rtt_valid_reg <= 1'b1;
                    state_reg <= S_RTT3;
                    newer_reg <= 1'b0;
                end else begin
                    srtt_new_reg <= 14'(srtt_sum >> 3);
                    srtt_reg <= 14'(srtt_sum >> 3);
                    state_reg <= S_RTT3;
                end
            end else begin
                newer_reg <= 1'b0;
                state_reg <= S_CLEAR;
                found_reg <= 1'b0;
            end
        end
        S_RTT3: begin
            // newer_reg still set: variance update pending, then rto.
            if (newer_reg) begin
                var_reg <= 14'(var_sum >> 2);
                newer_reg <= 1'b0;
            end else begin
                if (rto_sum < {6'd0, RTO_MIN}) rto_reg <= RTO_MIN;
                else if (rto_sum > {6'd0, RTO_MAX}) rto_reg <= RTO_MAX;
                else rto_reg <= rto_sum[11:0];
                state_reg <= S_CLEAR;
            end
        end
        S_CLEAR: begin
            if (valid_reg[k_idx] && d_ack[15]) begin
                valid_reg[k_idx] <= 1'b0;
                count_reg <= count_reg - 1'b1;
                cleared_reg <= cleared_reg + 1'b1;
            end
            if (k_reg == CNT_W'(WINDOW_SLOTS - 1)) begin
                state_reg <= S_OUT;
            end else k_reg <= k_reg + 1'b1;
        end
        S_TICK_RD: begin
            rs_valid_reg <= valid_reg[k_idx];
            rs_seq_reg <= seq_mem[k_idx];
            rs_time_reg <= time_mem[k_idx];
            rs_retry_reg <= retry_mem[k_idx];
            state_reg <= S_TICK;
        end
        S_TICK: begin
            if (rs_valid_reg && d_in && elapsed > {16'd0, rto_now}) begin
                if (out_free) begin
                    if (retry_inc > {1'b0, max_retries}) begin
                        res_valid_reg <= 1'b1;
                        res_reg <= '{kind: KIND_CLOSED, slot: 5'(k_idx), seq: rs_seq_reg,
                                     cleared: 6'd0, in_flight: 6'd0,
                                     rto_ms: default_rto, last: 1'b1};
                        valid_reg <= '0;
                        next_tx_reg <= 16'd0; last_acked_reg <= 16'd0;
                        dup_reg <= 8'd0; fast_done_reg <= 1'b0; rtt_valid_reg <= 1'b0;
                        srtt_reg <= 14'd0; var_reg <= 14'd0; rto_reg <= 12'd0;
                        count_reg <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        retry_mem[k_idx] <= retry_inc[7:0];
                        time_mem[k_idx] <= cur_reg.now_ms;
                        res_valid_reg <= 1'b1;
                        res_reg <= '{kind: KIND_RETX, slot: 5'(k_idx), seq: rs_seq_reg,
                                     cleared: 6'd0, in_flight: 6'(count_reg),
                                     rto_ms: rto_now, last: 1'b0};
                        rs_valid_reg <= 1'b0;
                    end
                end
            end else begin
                if (rs_valid_reg && d_stale) begin
                    valid_reg[k_idx] <= 1'b0;
                    count_reg <= count_reg - 1'b1;
                    cleared_reg <= cleared_reg + 1'b1;
                end
                if (k_reg == CNT_W'(WINDOW_SLOTS - 1)) state_reg <= S_OUT;
                else begin
                    k_reg <= k_reg + 1'b1;
                    state_reg <= S_TICK_RD;
                end
            end
        end
        S_OUT: begin
            if (out_free) begin
                res_valid_reg <= 1'b1;
                res_reg <= '{kind: KIND_DONE, slot: 5'd0,
                             seq: (cur_reg.command == CMD_ACK) ? cur_reg.ack_seq : 16'd0,
                             cleared: 6'(cleared_reg), in_flight: 6'(count_reg),
                             rto_ms: rto_now, last: 1'b1};
                state_reg <= S_IDLE;
            end
        end
        default: state_reg <= S_IDLE;
        endcase
        if (!aresetn) begin
            state_reg <= S_IDLE;
            res_valid_reg <= 1'b0;
            valid_reg <= '0;
            next_tx_reg <= 16'd0; last_acked_reg <= 16'd0;
            dup_reg <= 8'd0; fast_done_reg <= 1'b0; rtt_valid_reg <= 1'b0;
            srtt_reg <= 14'd0; var_reg <= 14'd0; rto_reg <= 12'd0;
            count_reg <= '0;
        end
    end

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(WINDOW_SLOTS)) else $error("window count overflow");
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (32'(count_reg) == $countones(valid_reg)))
        else $error("window count differs from valid slots");
    a_rto: assert property (@(posedge aclk) disable iff (!aresetn)
        rto_reg == 12'd0 || (rto_reg >= RTO_MIN && rto_reg <= RTO_MAX))
        else $error("rto out of range");
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !res_ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("result changed while waiting");
endmodule
`default_nettype wire

/* sv/arq_send_window_tracker.sv */
// Top level of the ARQ send window tracker: APB registers, request queue, engine.
// Send and unknown commands are answered directly from idle. Duplicate or older ack:
// one slot walk; newer ack: two slot walks plus RTT update.
// Tick: one slot walk with a retransmit per timed-out slot; result stalls lengthen all
// of these. Requests pass through the request queue; one request at a time in the engine.
// Reset: synchronous active-low aresetn empties the window and restores registers.
`default_nettype none
module arq_send_window_tracker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [55:0] s_tdata,   // command[1:0], ack_seq[17:2], now_ms[49:18]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [55:0] m_tdata,   // kind, slot, seq, cleared, in_flight, rto_ms
    output logic        m_tlast,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import arq_pkg::*;
    logic [15:0] def_rto_reg;
    logic [7:0]  max_retries_reg;
    req_t in_req, q_req;
    res_t r;
    logic q_valid, q_ready;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[2])
            REG_DEFAULT_RTO: prdata = {16'd0, def_rto_reg};
            REG_MAX_RETRIES: prdata = {24'd0, max_retries_reg};
            default: prdata = 32'd0;
        endcase
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_rto_reg <= 16'd1000;
            max_retries_reg <= 8'd10;
        end else if (psel && penable && pwrite) begin
            if (paddr == {REG_DEFAULT_RTO, 2'b00}) def_rto_reg <= pwdata[15:0];
            else if (paddr == {REG_MAX_RETRIES, 2'b00}) max_retries_reg <= pwdata[7:0];
        end
    end

    assign in_req = '{command: s_tdata[1:0], ack_seq: s_tdata[17:2], now_ms: s_tdata[49:18]};

    arq_req_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
    );

    arq_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(r),
        .default_rto(def_rto_reg), .max_retries(max_retries_reg)
    );

    assign m_tdata = {4'd0, r.rto_ms, r.in_flight, r.cleared, r.seq, r.slot, r.kind};
    assign m_tlast = r.last;
endmodule
`default_nettype wire
